// ===== rtl/tss_pkg.sv =====
// Package for the temperature to seven-segment scan block.
// Item type passed from front to back, segment codes, scan positions, digit table.
// No dependencies.
`timescale 1ns / 1ps

package tss_pkg;

  // input reading and scaled value widths
  localparam int RAW_W = 12;
  localparam int MAG_W = 12;
  localparam int VAL_W = 14;          // 2048 * 6.25 = 12800 fits in 14 bits
  localparam int NUM_DIGITS = 5;
  localparam int DIV_STEPS = NUM_DIGITS - 1;
  localparam int STEP_W = $clog2(DIV_STEPS);

  // x / 10 == (x * 52429) >> 19, exact for x below 43699
  localparam int RECIP_W = 16;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
  localparam int QUO_W = VAL_W - 3;

  // value thresholds for tens and hundreds blanking
  localparam logic [VAL_W-1:0] TENS_LIMIT = 14'd999;
  localparam logic [VAL_W-1:0] HUND_LIMIT = 14'd9999;

  // rounding scale: v = (25 * m + 2) >> 2
  localparam int PROD_W = 16;
  localparam logic [PROD_W-1:0] SCALE_MUL = 16'd25;
  localparam logic [PROD_W-1:0] SCALE_RND = 16'd2;

  // scan layout
  localparam int SCAN_POSITIONS = 8;
  localparam int POS_W = $clog2(SCAN_POSITIONS);
  localparam logic [POS_W-1:0] POS_SYMBOL     = 3'd0;
  localparam logic [POS_W-1:0] POS_HUNDREDTHS = 3'd1;
  localparam logic [POS_W-1:0] POS_TENTHS     = 3'd2;
  localparam logic [POS_W-1:0] POS_UNITS      = 3'd3;
  localparam logic [POS_W-1:0] POS_TENS       = 3'd4;
  localparam logic [POS_W-1:0] POS_HUNDREDS   = 3'd5;
  localparam logic [POS_W-1:0] POS_SIGN       = 3'd6;
  localparam logic [POS_W-1:0] POS_BLANK      = 3'd7;

  // segment codes
  localparam logic [7:0] SEG_C     = 8'h39;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_OFF   = 8'h00;

  // default queue depth between front and back
  localparam int DEF_QUEUE_DEPTH = 2;

  // one classified reading, digits least significant first
  typedef struct packed {
    logic                      neg;
    logic                      show_tens;
    logic                      show_hund;
    logic [NUM_DIGITS-1:0][3:0] digit;
  } tss_item_t;

  // decimal digit to segment pattern
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/temperature_to_seven_segment_scan.sv =====
// Top level of the temperature to seven-segment scan block.
// Depends on tss_pkg, tss_front, tss_queue and tss_back.
`timescale 1ns / 1ps

// Takes one signed reading in sixteenths of a degree and returns eight scan
// results, positions 0 to 7: the C symbol, hundredths, tenths, units with the
// decimal point, tens and hundreds (blanked when not needed), the minus sign,
// and an undriven position marked by segments_valid low and last high.
// Results leave one per cycle while out_stall is low, and the back end pops
// a reading after its eighth result. The front end works through accept,
// four reciprocal-multiply digit steps and push for each reading, so it runs
// ahead and fills the queue while the back end scans. With the queue empty,
// a reading's first result follows the digit steps, the push and the back
// end's output register. Both channels use valid/stall; there is no
// initialization sweep after reset.
module temperature_to_seven_segment_scan import tss_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] raw_reading,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [POS_W-1:0]        scan_position,
  output logic [7:0]              segments,
  output logic                    segments_valid,
  output logic                    last
);

  logic      push_valid;
  logic      push_full;
  tss_item_t push_item;
  logic      pop_valid;
  logic      pop;
  tss_item_t pop_item;

  // classify and split into digits
  tss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_reading (raw_reading),
    .push_valid  (push_valid),
    .push_full   (push_full),
    .push_item   (push_item)
  );

  // decoupling queue
  tss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // position scan
  tss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (pop_valid),
    .item           (pop_item),
    .item_pop       (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scan_position  (scan_position),
    .segments       (segments),
    .segments_valid (segments_valid),
    .last           (last)
  );

endmodule

// ===== rtl/tss_front.sv =====
// Front end: accepts a reading, scales it to hundredths and splits it into digits.
// Depends on tss_pkg. Feeds tss_queue.
`timescale 1ns / 1ps

module tss_front import tss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] raw_reading,
  output logic                    push_valid,
  input  logic                    push_full,
  output tss_item_t               push_item
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  front_state_t           state;
  logic [STEP_W-1:0]      step;
  logic [VAL_W-1:0]       x;
  tss_item_t              work;

  logic                   accept;
  logic [MAG_W-1:0]       raw_u;
  logic [MAG_W-1:0]       mag;
  logic [PROD_W-1:0]      scaled;
  logic [VAL_W-1:0]       val;
  logic [VAL_W+RECIP_W-1:0] recip_prod;
  logic [QUO_W-1:0]       quo;
  logic [VAL_W-1:0]       ten_quo;
  logic [VAL_W-1:0]       rem_full;

  assign in_stall   = (state != F_IDLE);
  assign accept     = in_valid && !in_stall;
  assign push_valid = (state == F_PUSH);
  assign push_item  = work;

  // magnitude and rounded scaling
  always_comb begin
    raw_u  = MAG_W'(raw_reading);
    mag    = raw_u[MAG_W-1] ? (~raw_u + MAG_W'(1)) : raw_u;
    scaled = PROD_W'(mag) * SCALE_MUL + SCALE_RND;
    val    = scaled[VAL_W+1:2];
  end

  // one decimal digit per step by reciprocal multiply
  always_comb begin
    recip_prod = (VAL_W+RECIP_W)'(x) * (VAL_W+RECIP_W)'(RECIP_TEN);
    quo        = recip_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    ten_quo    = VAL_W'({quo, 3'b000}) + VAL_W'({quo, 1'b0});
    rem_full   = x - ten_quo;
  end

  // sequencer and item build-up
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state          <= F_DIV;
            step           <= '0;
            x              <= val;
            work.neg       <= raw_reading[RAW_W-1];
            work.show_tens <= (val > TENS_LIMIT);
            work.show_hund <= (val > HUND_LIMIT);
          end
        end
        F_DIV: begin
          work.digit[step] <= rem_full[3:0];
          x                <= VAL_W'(quo);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            work.digit[NUM_DIGITS-1] <= quo[3:0];
            state                    <= F_PUSH;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        F_PUSH: begin
          if (!push_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tss_queue.sv =====
// Short queue of classified readings between front and back.
// Depends on tss_pkg for the item type.
`timescale 1ns / 1ps

module tss_queue import tss_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_full,
  input  tss_item_t push_item,
  output logic      pop_valid,
  input  logic      pop,
  output tss_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tss_item_t          entry [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_full = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entry[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/tss_back.sv =====
// Back end: scans the queue head's eight positions, one per unstalled cycle.
// Depends on tss_pkg. Reads from tss_queue, drives the output register.
`timescale 1ns / 1ps

module tss_back import tss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  tss_item_t        item,
  output logic             item_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [POS_W-1:0] scan_position,
  output logic [7:0]       segments,
  output logic             segments_valid,
  output logic             last
);

  logic [POS_W-1:0] pos;
  logic             load;
  logic [7:0]       pattern;
  logic             is_last;

  assign load     = item_valid && (!out_valid || !out_stall);
  assign is_last  = (pos == POS_W'(SCAN_POSITIONS - 1));
  assign item_pop = load && is_last;

  // segment pattern for the current position
  always_comb begin
    unique case (pos)
      POS_SYMBOL:     pattern = SEG_C;
      POS_HUNDREDTHS: pattern = seg_of(item.digit[0]);
      POS_TENTHS:     pattern = seg_of(item.digit[1]);
      POS_UNITS:      pattern = seg_of(item.digit[2]) | SEG_DP;
      POS_TENS:       pattern = item.show_tens ? seg_of(item.digit[3]) : SEG_OFF;
      POS_HUNDREDS:   pattern = item.show_hund ? seg_of(item.digit[4]) : SEG_OFF;
      POS_SIGN:       pattern = item.neg ? SEG_MINUS : SEG_OFF;
      POS_BLANK:      pattern = SEG_OFF;
      default:        pattern = SEG_OFF;
    endcase
  end

  // position counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid      <= 1'b1;
      scan_position  <= pos;
      segments       <= pattern;
      segments_valid <= (pos != POS_BLANK);
      last           <= is_last;
      pos            <= is_last ? '0 : pos + POS_W'(1);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/tss_checker.sv =====
// Port-level checks on the scan output of temperature_to_seven_segment_scan.
// Depends on tss_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module tss_checker import tss_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [POS_W-1:0] scan_position,
  input logic [7:0]       segments,
  input logic             segments_valid,
  input logic             last
);

  // a stalled request holds its position and segments
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scan_position) && $stable(segments))
    else $error("stalled scan request changed");

  // a run continues at the next position without a gap
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=>
      out_valid && (scan_position == $past(scan_position) + POS_W'(1)))
    else $error("scan run broke or skipped a position");

  // the blank position ends the run and drives nothing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (scan_position == POS_BLANK) |->
      last && !segments_valid && (segments == SEG_OFF))
    else $error("blank position malformed");

  // every other position is driven and not last
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (scan_position != POS_BLANK) |-> segments_valid && !last)
    else $error("driven position malformed");

  // position zero always shows the symbol
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (scan_position == POS_SYMBOL) |-> (segments == SEG_C))
    else $error("symbol position shows wrong segments");

endmodule

bind temperature_to_seven_segment_scan tss_checker u_tss_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .scan_position  (scan_position),
  .segments       (segments),
  .segments_valid (segments_valid),
  .last           (last)
);

// ===== tb/sv/temperature_to_seven_segment_scan_tb.sv =====
// Testbench for temperature_to_seven_segment_scan: drives signed readings,
// predicts the eight scan results of each one and checks them in order.
// Depends on tss_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module temperature_to_seven_segment_scan_tb;
  import tss_pkg::*;

  // one expected scan result
  typedef struct {
    logic [POS_W-1:0] pos;
    logic [7:0]       segs;
    logic             driven;
    logic             last;
  } scan_result_t;

  // digit 0..9 to segment pattern
  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [RAW_W-1:0] raw_reading;
  logic                    out_valid;
  logic                    out_stall;
  logic [POS_W-1:0]        scan_position;
  logic [7:0]              segments;
  logic                    segments_valid;
  logic                    last;

  scan_result_t expected_scans[$];
  int           fail_count = 0;
  bit           tx_idle_on = 1'b0;
  bit           rx_idle_on = 1'b0;
  int           hold_left = 0;
  int           stall_left = 0;

  temperature_to_seven_segment_scan u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .raw_reading   (raw_reading),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scan_position (scan_position),
    .segments      (segments),
    .segments_valid(segments_valid),
    .last          (last)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected scan of one reading: symbol, three digits, tens and hundreds
  // (blanked below their thresholds), sign, then the undriven slot
  function automatic void predict_scan(input logic signed [RAW_W-1:0] value);
    scan_result_t r;
    logic         neg;
    int           mag;
    int           hund_val;
    logic [7:0]   pattern [SCAN_POSITIONS];
    neg = value[RAW_W-1];
    mag = neg ? -int'(value) : int'(value);
    hund_val = (25 * mag + 2) >> 2;
    pattern[POS_SYMBOL]     = SEG_C;
    pattern[POS_HUNDREDTHS] = DIGIT_SEGS[hund_val % 10];
    pattern[POS_TENTHS]     = DIGIT_SEGS[(hund_val / 10) % 10];
    pattern[POS_UNITS]      = DIGIT_SEGS[(hund_val / 100) % 10] | SEG_DP;
    pattern[POS_TENS]       = (hund_val > int'(TENS_LIMIT)) ?
                              DIGIT_SEGS[(hund_val / 1000) % 10] : SEG_OFF;
    pattern[POS_HUNDREDS]   = (hund_val > int'(HUND_LIMIT)) ?
                              DIGIT_SEGS[(hund_val / 10000) % 10] : SEG_OFF;
    pattern[POS_SIGN]       = neg ? SEG_MINUS : SEG_OFF;
    pattern[POS_BLANK]      = SEG_OFF;
    for (int k = 0; k < SCAN_POSITIONS; k++) begin
      r.pos    = k[POS_W-1:0];
      r.driven = (k[POS_W-1:0] != POS_BLANK);
      r.segs   = r.driven ? pattern[k] : SEG_OFF;
      r.last   = (k == SCAN_POSITIONS - 1);
      expected_scans.push_back(r);
    end
  endfunction

  // offer one request, starting and ending at a falling edge
  task automatic send_reading(input logic signed [RAW_W-1:0] value);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    raw_reading <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_scan(value);
    @(negedge clk);
  endtask

  // reading of magnitude mag, negated when neg is set
  function automatic logic signed [RAW_W-1:0] signed_reading(input int mag, input bit neg);
    logic signed [RAW_W-1:0] v;
    v = mag[RAW_W-1:0];
    return neg ? -v : v;
  endfunction

  // receiver: random stall bursts plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_scans.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: pos %0d seg %h drv %b last %b",
                   scan_position, segments, segments_valid, last);
      end else begin
        want = expected_scans.pop_front();
        if (scan_position !== want.pos || segments !== want.segs ||
            segments_valid !== want.driven || last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp pos %0d seg %h drv %b last %b, got pos %0d seg %h drv %b last %b",
                     want.pos, want.segs, want.driven, want.last,
                     scan_position, segments, segments_valid, last);
        end
      end
    end
  end

  // extremes, blanking thresholds, rounding, zero and small negatives
  task automatic test_directed();
    send_reading(-12'sd2048);
    send_reading(12'sd2047);
    send_reading(-12'sd2047);
    send_reading(12'sd0);
    send_reading(-12'sd1);
    send_reading(12'sd1);
    send_reading(12'sd2);
    send_reading(-12'sd2);
    send_reading(signed_reading(159, 0));
    send_reading(signed_reading(160, 0));
    send_reading(signed_reading(160, 1));
    send_reading(signed_reading(1599, 0));
    send_reading(signed_reading(1600, 0));
    send_reading(signed_reading(1600, 1));
    send_reading(signed_reading(1599, 1));
    send_reading(12'sh555);
    send_reading(12'shAAA);
  endtask

  // random readings, weighted toward thresholds and small values
  task automatic test_random(input int count);
    int mag;
    bit neg;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      neg = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_reading(RAW_W'($urandom_range(0, 4095)));
        5, 6: begin
          mag = $urandom_range(0, 40);
          send_reading(signed_reading(mag, neg));
        end
        7: begin
          mag = $urandom_range(155, 165);
          send_reading(signed_reading(mag, neg));
        end
        8: begin
          mag = $urandom_range(1595, 1605);
          send_reading(signed_reading(mag, neg));
        end
        default: begin
          mag = $urandom_range(2040, 2048);
          send_reading(signed_reading(mag, neg));
        end
      endcase
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left  = 120;
    for (int i = 0; i < 8; i++) send_reading(RAW_W'($urandom_range(0, 4095)));
  endtask

  // back-to-back traffic with no idling at all
  task automatic test_steady(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_reading(RAW_W'($urandom_range(0, 4095)));
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    raw_reading = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(190);
    test_backpressure();
    test_steady(20);

    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && expected_scans.size() == 0) begin
      $display("temperature_to_seven_segment_scan_tb OK");
    end else begin
      $display("temperature_to_seven_segment_scan_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("temperature_to_seven_segment_scan_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tss_pkg.sv
rtl/tss_front.sv
rtl/tss_queue.sv
rtl/tss_back.sv
rtl/temperature_to_seven_segment_scan.sv
rtl/tss_checker.sv
tb/sv/temperature_to_seven_segment_scan_tb.sv
